// File: rtl/rau_pkg.sv
// rau_pkg: shared constants for the rational arithmetic unit
// command codes, order codes, the default operand width and fixed result field widths; no dependencies
`default_nettype none

package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_NUM_W         = 33;
    localparam int RES_DEN_W         = 31;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] order_t;

    localparam cmd_t CMD_ADD = 2'd0;
    localparam cmd_t CMD_SUB = 2'd1;
    localparam cmd_t CMD_MUL = 2'd2;
    localparam cmd_t CMD_DIV = 2'd3;

    localparam order_t ORDER_LESS    = 2'd0;
    localparam order_t ORDER_EQUAL   = 2'd1;
    localparam order_t ORDER_GREATER = 2'd2;

endpackage

`default_nettype wire

// File: rtl/rational_arithmetic_unit.sv
// rational_arithmetic_unit: adds, subtracts, multiplies or divides two signed fractions
// and reduces the result by its gcd, and reports the order of a against b; depends on rau_pkg
//
//   channel   direction  handshake                     payload
//   operand   in         operand_valid / operand_stall command, a_*, b_*
//   result    out        result_valid / result_stall   result_numerator, result_denominator,
//                                                      order, error
//
// one shared multiplier, one binary gcd step unit and one restoring divider under a sequencer
// an item passes the multiply and compare states (S_MP, S_MQ, S_CMP, S_MD, S_MN), the gcd steps,
// the divider steps for the numerator and then for the denominator, and S_DONE to hand over
// zero denominators, a zero divisor and a zero numerator finish early
// operand_stall is high while an item is at work; the result register holds while stalled
// rst_n clears the sequencer and result_valid at once
`default_nettype none

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              operand_valid,
    output logic                              operand_stall,
    input  logic [1:0]                        command,
    input  logic signed [OPERAND_WIDTH-1:0]   a_numerator,
    input  logic        [OPERAND_WIDTH-2:0]   a_denominator,
    input  logic signed [OPERAND_WIDTH-1:0]   b_numerator,
    input  logic        [OPERAND_WIDTH-2:0]   b_denominator,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [RES_NUM_W-1:0]       result_numerator,
    output logic        [RES_DEN_W-1:0]       result_denominator,
    output logic [1:0]                        order,
    output logic                              error
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int KW = $clog2(MW);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MP   = 4'd1;
    localparam logic [3:0] S_MQ   = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_MD   = 4'd4;
    localparam logic [3:0] S_MN   = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DIVN = 4'd7;
    localparam logic [3:0] S_DIVD = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    localparam logic [KW-1:0] CNT_LAST = KW'(MW - 1);

    logic [3:0]            state_reg, state_next;
    logic                  result_valid_reg, result_valid_next;

    cmd_t                  cmd_reg, cmd_next;
    logic                  an_neg_reg, an_neg_next;
    logic                  bn_neg_reg, bn_neg_next;
    logic [W-1:0]          an_mag_reg, an_mag_next;
    logic [W-1:0]          bn_mag_reg, bn_mag_next;
    logic [W-2:0]          ad_reg, ad_next;
    logic [W-2:0]          bd_reg, bd_next;
    logic [MW-1:0]         p_mag_reg, p_mag_next;
    logic                  p_neg_reg, p_neg_next;
    logic [MW-1:0]         q_mag_reg, q_mag_next;
    logic                  q_neg_reg, q_neg_next;
    logic [MW-1:0]         den_mag_reg, den_mag_next;
    logic [MW-1:0]         num_mag_reg, num_mag_next;
    logic                  sign_reg, sign_next;
    logic [MW-1:0]         gx_reg, gx_next;
    logic [MW-1:0]         gy_reg, gy_next;
    logic [KW-1:0]         gk_reg, gk_next;
    logic [MW-1:0]         g_reg, g_next;
    logic [MW-1:0]         rem_reg, rem_next;
    logic [MW-1:0]         quo_reg, quo_next;
    logic [KW-1:0]         cnt_reg, cnt_next;
    logic [RES_NUM_W-1:0]  fin_num_reg, fin_num_next;
    logic [RES_DEN_W-1:0]  fin_den_reg, fin_den_next;
    order_t                order_reg, order_next;
    logic                  err_reg, err_next;
    logic [RES_NUM_W-1:0]  res_num_reg, res_num_next;
    logic [RES_DEN_W-1:0]  res_den_reg, res_den_next;
    order_t                res_order_reg, res_order_next;
    logic                  res_err_reg, res_err_next;

    logic [W-1:0]          mul_a, mul_b;
    logic [MW-1:0]         prod;
    logic [MW-1:0]         q_add_mag;
    logic                  q_add_neg;
    logic [MW-1:0]         sum_mag;
    logic                  sum_neg;
    logic [MW-1:0]         mn_mag;
    logic                  mn_neg;
    order_t                cmp_order;
    logic [MW:0]           rem_shift;
    logic                  div_take;
    logic [MW-1:0]         rem_step, quo_step;
    logic [MW+RES_NUM_W-1:0] quo_wide;
    logic [RES_NUM_W-1:0]  nm_trunc;

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MP:
            begin
                mul_a = an_mag_reg;
                mul_b = {1'b0, bd_reg};
            end
            S_MQ:
            begin
                mul_a = bn_mag_reg;
                mul_b = {1'b0, ad_reg};
            end
            S_MD:
            begin
                mul_a = {1'b0, ad_reg};
                mul_b = (cmd_reg == CMD_DIV) ? bn_mag_reg : {1'b0, bd_reg};
            end
            S_MN:
            begin
                mul_a = an_mag_reg;
                mul_b = bn_mag_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = MW'(mul_a) * MW'(mul_b);

    // sign-magnitude add of the cross products
    always_comb
    begin
        q_add_mag = q_mag_reg;
        q_add_neg = (cmd_reg == CMD_SUB) ? (!q_neg_reg && q_mag_reg != '0) : q_neg_reg;
        if (p_neg_reg == q_add_neg)
        begin
            sum_mag = p_mag_reg + q_add_mag;
            sum_neg = p_neg_reg;
        end
        else if (p_mag_reg >= q_add_mag)
        begin
            sum_mag = p_mag_reg - q_add_mag;
            sum_neg = p_neg_reg;
        end
        else
        begin
            sum_mag = q_add_mag - p_mag_reg;
            sum_neg = q_add_neg;
        end
        if (sum_mag == '0)
        begin
            sum_neg = 1'b0;
        end
    end

    // raw numerator by command
    always_comb
    begin
        case (cmd_reg)
            CMD_ADD, CMD_SUB:
            begin
                mn_mag = sum_mag;
                mn_neg = sum_neg;
            end
            CMD_MUL:
            begin
                mn_mag = prod;
                mn_neg = (an_neg_reg != bn_neg_reg) && prod != '0;
            end
            default:
            begin
                mn_mag = p_mag_reg;
                mn_neg = p_neg_reg;
            end
        endcase
    end

    // compare a against b by cross products
    always_comb
    begin
        if (p_neg_reg != q_neg_reg)
        begin
            cmp_order = p_neg_reg ? ORDER_LESS : ORDER_GREATER;
        end
        else if (p_mag_reg == q_mag_reg)
        begin
            cmp_order = ORDER_EQUAL;
        end
        else if (p_neg_reg)
        begin
            cmp_order = (p_mag_reg > q_mag_reg) ? ORDER_LESS : ORDER_GREATER;
        end
        else
        begin
            cmp_order = (p_mag_reg > q_mag_reg) ? ORDER_GREATER : ORDER_LESS;
        end
    end

    // restoring divider step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[MW-1]};
        div_take  = rem_shift >= {1'b0, g_reg};
        rem_step  = div_take ? MW'(rem_shift - {1'b0, g_reg}) : rem_shift[MW-1:0];
        quo_step  = {quo_reg[MW-2:0], div_take};
    end

    assign quo_wide = {{RES_NUM_W{1'b0}}, quo_step};
    assign nm_trunc = quo_wide[RES_NUM_W-1:0];

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        cmd_next          = cmd_reg;
        an_neg_next       = an_neg_reg;
        bn_neg_next       = bn_neg_reg;
        an_mag_next       = an_mag_reg;
        bn_mag_next       = bn_mag_reg;
        ad_next           = ad_reg;
        bd_next           = bd_reg;
        p_mag_next        = p_mag_reg;
        p_neg_next        = p_neg_reg;
        q_mag_next        = q_mag_reg;
        q_neg_next        = q_neg_reg;
        den_mag_next      = den_mag_reg;
        num_mag_next      = num_mag_reg;
        sign_next         = sign_reg;
        gx_next           = gx_reg;
        gy_next           = gy_reg;
        gk_next           = gk_reg;
        g_next            = g_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        cnt_next          = cnt_reg;
        fin_num_next      = fin_num_reg;
        fin_den_next      = fin_den_reg;
        order_next        = order_reg;
        err_next          = err_reg;
        res_num_next      = res_num_reg;
        res_den_next      = res_den_reg;
        res_order_next    = res_order_reg;
        res_err_next      = res_err_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (operand_valid)
                begin
                    cmd_next     = command;
                    an_neg_next  = a_numerator[W-1];
                    bn_neg_next  = b_numerator[W-1];
                    an_mag_next  = a_numerator[W-1] ? (~a_numerator + W'(1)) : a_numerator;
                    bn_mag_next  = b_numerator[W-1] ? (~b_numerator + W'(1)) : b_numerator;
                    ad_next      = a_denominator;
                    bd_next      = b_denominator;
                    err_next     = 1'b0;
                    order_next   = ORDER_EQUAL;
                    fin_num_next = '0;
                    fin_den_next = RES_DEN_W'(1);
                    if (a_denominator == '0 || b_denominator == '0)
                    begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MP;
                    end
                end
            end
            S_MP:
            begin
                p_mag_next = prod;
                p_neg_next = an_neg_reg && prod != '0;
                state_next = S_MQ;
            end
            S_MQ:
            begin
                q_mag_next = prod;
                q_neg_next = bn_neg_reg && prod != '0;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                order_next = cmp_order;
                if (cmd_reg == CMD_DIV && bn_mag_reg == '0)
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MD;
                end
            end
            S_MD:
            begin
                den_mag_next = prod;
                state_next   = S_MN;
            end
            S_MN:
            begin
                num_mag_next = mn_mag;
                sign_next    = mn_neg != ((cmd_reg == CMD_DIV) && bn_neg_reg);
                gx_next      = mn_mag;
                gy_next      = den_mag_reg;
                gk_next      = '0;
                state_next   = (mn_mag == '0) ? S_DONE : S_GCD;
            end
            S_GCD:
            begin
                if (!gx_reg[0] && !gy_reg[0])
                begin
                    gx_next = gx_reg >> 1;
                    gy_next = gy_reg >> 1;
                    gk_next = gk_reg + KW'(1);
                end
                else if (!gx_reg[0])
                begin
                    gx_next = gx_reg >> 1;
                end
                else if (!gy_reg[0])
                begin
                    gy_next = gy_reg >> 1;
                end
                else if (gx_reg == gy_reg)
                begin
                    g_next     = gx_reg << gk_reg;
                    quo_next   = num_mag_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIVN;
                end
                else if (gx_reg > gy_reg)
                begin
                    gx_next = (gx_reg - gy_reg) >> 1;
                end
                else
                begin
                    gy_next = (gy_reg - gx_reg) >> 1;
                end
            end
            S_DIVN:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + KW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    fin_num_next = sign_reg ? (~nm_trunc + RES_NUM_W'(1)) : nm_trunc;
                    quo_next     = den_mag_reg;
                    rem_next     = '0;
                    cnt_next     = '0;
                    state_next   = S_DIVD;
                end
            end
            S_DIVD:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + KW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    fin_den_next = quo_wide[RES_DEN_W-1:0];
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    res_num_next      = fin_num_reg;
                    res_den_next      = fin_den_reg;
                    res_order_next    = order_reg;
                    res_err_next      = err_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        an_neg_reg    <= an_neg_next;
        bn_neg_reg    <= bn_neg_next;
        an_mag_reg    <= an_mag_next;
        bn_mag_reg    <= bn_mag_next;
        ad_reg        <= ad_next;
        bd_reg        <= bd_next;
        p_mag_reg     <= p_mag_next;
        p_neg_reg     <= p_neg_next;
        q_mag_reg     <= q_mag_next;
        q_neg_reg     <= q_neg_next;
        den_mag_reg   <= den_mag_next;
        num_mag_reg   <= num_mag_next;
        sign_reg      <= sign_next;
        gx_reg        <= gx_next;
        gy_reg        <= gy_next;
        gk_reg        <= gk_next;
        g_reg         <= g_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        fin_num_reg   <= fin_num_next;
        fin_den_reg   <= fin_den_next;
        order_reg     <= order_next;
        err_reg       <= err_next;
        res_num_reg   <= res_num_next;
        res_den_reg   <= res_den_next;
        res_order_reg <= res_order_next;
        res_err_reg   <= res_err_next;
    end

    assign operand_stall      = (state_reg != S_IDLE);
    assign result_valid       = result_valid_reg;
    assign result_numerator   = res_num_reg;
    assign result_denominator = res_den_reg;
    assign order              = res_order_reg;
    assign error              = res_err_reg;

endmodule

`default_nettype wire
